[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the deframer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define DFRM_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked check, live during reset as well
`define DFRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/dfrm_pkg.sv]
// ----------------------------------------------------------------------------
// dfrm_pkg
// shared types and constants of the length-prefixed packet deframer
// ----------------------------------------------------------------------------
package dfrm_pkg;

	localparam logic [7:0] START_BYTE = 8'hAF;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_DONE    = 1'b1;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  payload_byte;
		logic        last_payload;
		logic [7:0]  flag_bits;
		logic [15:0] packet_type;
		logic [31:0] packet_size;
		logic [7:0]  check_byte;
	} dfrm_res_t;

endpackage

[hdl/dfrm_in_if.sv]
// ----------------------------------------------------------------------------
// dfrm_in_if
// byte stream channel into the deframer
// ----------------------------------------------------------------------------
interface dfrm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

[hdl/dfrm_out_if.sv]
// ----------------------------------------------------------------------------
// dfrm_out_if
// result channel out of the deframer: payload bytes and packet reports
// ----------------------------------------------------------------------------
interface dfrm_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic        last_payload;
	logic [7:0]  flag_bits;
	logic [15:0] packet_type;
	logic [31:0] packet_size;
	logic [7:0]  check_byte;

	modport source (
		output valid, output result_kind, output payload_byte, output last_payload,
		output flag_bits, output packet_type, output packet_size, output check_byte,
		input ready
	);
	modport sink (
		input valid, input result_kind, input payload_byte, input last_payload,
		input flag_bits, input packet_type, input packet_size, input check_byte,
		output ready
	);
endinterface

[hdl/dfrm_parser.sv]
// ----------------------------------------------------------------------------
// dfrm_parser
// header capture, payload counting and result formation, one byte per request
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfrm_parser
	import dfrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] in_byte,
	output logic       hit,
	output dfrm_res_t  res
);

	typedef enum logic [3:0] {
		PH_HUNT    = 4'd0,
		PH_FLAGS   = 4'd1,
		PH_TYPE_HI = 4'd2,
		PH_TYPE_LO = 4'd3,
		PH_SIZE_3  = 4'd4,
		PH_SIZE_2  = 4'd5,
		PH_SIZE_1  = 4'd6,
		PH_SIZE_0  = 4'd7,
		PH_PAYLOAD = 4'd8,
		PH_CHECK   = 4'd9
	} phase_t;

	phase_t      phase_q;
	logic [7:0]  flags_q;
	logic [15:0] type_q;
	logic [31:0] size_q;
	logic [31:0] left_q;
	logic [31:0] size_full;
	logic        last;

	assign size_full = {size_q[31:8], in_byte};
	assign last      = (left_q[31:1] == 31'd0);

	always_comb begin
		res  = '0;
		hit  = 1'b0;
		unique case (phase_q)
			PH_PAYLOAD: begin
				hit              = 1'b1;
				res.result_kind  = KIND_PAYLOAD;
				res.payload_byte = in_byte;
				res.last_payload = last;
			end
			PH_CHECK: begin
				hit             = 1'b1;
				res.result_kind = KIND_DONE;
				res.flag_bits   = flags_q;
				res.packet_type = type_q;
				res.packet_size = size_q;
				res.check_byte  = in_byte;
			end
			default: begin
				hit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			flags_q <= '0;
			type_q  <= '0;
			size_q  <= '0;
			left_q  <= '0;
		end else if (take) begin
			unique case (phase_q)
				PH_FLAGS: begin
					flags_q <= in_byte;
					phase_q <= PH_TYPE_HI;
				end
				PH_TYPE_HI: begin
					type_q  <= {in_byte, 8'd0};
					phase_q <= PH_TYPE_LO;
				end
				PH_TYPE_LO: begin
					type_q  <= {type_q[15:8], in_byte};
					phase_q <= PH_SIZE_3;
				end
				PH_SIZE_3: begin
					size_q  <= {in_byte, 24'd0};
					phase_q <= PH_SIZE_2;
				end
				PH_SIZE_2: begin
					size_q  <= {size_q[31:24], in_byte, 16'd0};
					phase_q <= PH_SIZE_1;
				end
				PH_SIZE_1: begin
					size_q  <= {size_q[31:16], in_byte, 8'd0};
					phase_q <= PH_SIZE_0;
				end
				PH_SIZE_0: begin
					size_q  <= size_full;
					left_q  <= size_full;
					phase_q <= (size_full != 32'd0) ? PH_PAYLOAD : PH_CHECK;
				end
				PH_PAYLOAD: begin
					if (left_q != 32'd0) begin
						left_q <= left_q - 32'd1;
					end
					if (last) begin
						phase_q <= PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_q <= PH_HUNT;
				end
				default: begin
					phase_q <= (in_byte == START_BYTE) ? PH_FLAGS : PH_HUNT;
				end
			endcase
		end
	end

	`DFRM_ASSERT(a_payload_count_live, clk, arst_n,
		(phase_q == PH_PAYLOAD) |-> (left_q != 32'd0), "payload phase with no bytes left")
	`DFRM_ASSERT(a_done_returns_hunt, clk, arst_n,
		(take && phase_q == PH_CHECK) |=> (phase_q == PH_HUNT), "report did not end packet")
	`DFRM_ASSERT(a_last_leaves_payload, clk, arst_n,
		(take && phase_q == PH_PAYLOAD && last) |=> (phase_q == PH_CHECK),
		"last payload byte did not move to checksum")

endmodule

[hdl/dfrm_out_reg.sv]
// ----------------------------------------------------------------------------
// dfrm_out_reg
// result register that lets a new request in while the held result drains
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dfrm_out_reg
	import dfrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  dfrm_res_t  res,
	output logic       free,
	dfrm_out_if.source result
);

	logic      valid_q;
	dfrm_res_t res_q;

	assign free = !valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_q <= res;
		end
	end

	assign result.valid        = valid_q;
	assign result.result_kind  = res_q.result_kind;
	assign result.payload_byte = res_q.payload_byte;
	assign result.last_payload = res_q.last_payload;
	assign result.flag_bits    = res_q.flag_bits;
	assign result.packet_type  = res_q.packet_type;
	assign result.packet_size  = res_q.packet_size;
	assign result.check_byte   = res_q.check_byte;

	`DFRM_ASSERT(a_load_only_when_free, clk, arst_n,
		load |-> free, "result loaded over a held one")
	`DFRM_ASSERT_ALWAYS(a_reset_empty, clk,
		!arst_n |=> !valid_q, "result valid out of reset")

endmodule

[hdl/sync_length_packet_deframer.sv]
// ----------------------------------------------------------------------------
// sync_length_packet_deframer
// length-prefixed packet deframer, one stream byte per request
// ----------------------------------------------------------------------------
// the stream channel carries one raw byte per request. bytes are dropped until
// the start byte 0xaf, then a flags byte, a big-endian 16-bit type and a
// big-endian 32-bit size are captured. every payload byte leaves on the result
// channel as its own request, the final one marked by last_payload; a zero size
// has no payload requests. the byte after the payload is returned as check_byte
// in a packet-complete request with flags, type and size.
// a result is registered and valid the cycle after the byte that caused it is taken.
// throughput: one byte per cycle, set by the single result register; a new byte
// is taken whenever that register is empty or is being drained in the same cycle.
// when the receiver stalls, the held result stays and stream.ready drops until
// it is taken. reset clears the parse state to hunting and empties the result.
// ----------------------------------------------------------------------------
module sync_length_packet_deframer
	import dfrm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	dfrm_in_if.sink    stream,
	dfrm_out_if.source result
);

	logic      take;
	logic      hit;
	logic      free;
	dfrm_res_t res;

	assign stream.ready = free;
	assign take         = stream.valid && free;

	dfrm_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.in_byte (stream.in_byte),
		.hit     (hit),
		.res     (res)
	);

	dfrm_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (take && hit),
		.res    (res),
		.free   (free),
		.result (result)
	);

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the length-prefixed packet deframer
// ----------------------------------------------------------------------------
// a short directed stream (idle bytes, an empty packet with all-ones flags
// and type, a one-byte packet whose payload is the start byte) is followed by
// random framed packets separated by idle noise. a predictor tracks the parse
// state and queues the payload and packet-complete results each stream byte
// should cause; every result request is checked field by field against the
// oldest queued result. the sender runs in random bursts and pauses until the
// result queue drains, the receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module tb_top;
	import dfrm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RUN_LIMIT    = 200000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_REPORTS  = 10;

	typedef enum logic [3:0] {
		PH_HUNT, PH_FLAGS, PH_TYPE_HI, PH_TYPE_LO,
		PH_SIZE_3, PH_SIZE_2, PH_SIZE_1, PH_SIZE_0,
		PH_PAYLOAD, PH_CHECK
	} parse_phase_t;

	typedef struct packed {
		logic       hold;
		logic [7:0] data;
	} wire_item_t;

	logic clk = 1'b0;
	logic arst_n;

	dfrm_in_if  stream_if ();
	dfrm_out_if result_if ();

	sync_length_packet_deframer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream_if.sink),
		.result (result_if.source)
	);

	always #5 clk = ~clk;

	wire_item_t wire_bytes[$];
	dfrm_res_t  pending_results[$];
	int         stream_count = 0;
	int         mismatches   = 0;
	int         cycles       = 0;

	parse_phase_t phase      = PH_HUNT;
	logic [7:0]   held_flags = '0;
	logic [15:0]  held_type  = '0;
	logic [31:0]  held_size  = '0;
	logic [31:0]  bytes_left = '0;

	int burst_left = 0;
	int gap_left   = 0;
	int settle     = 0;
	int stall_mode = 0;
	int stall_span = 0;
	int stall_tick = 0;

	task automatic deframe_byte(input logic [7:0] b);
		dfrm_res_t r;
		r = '0;
		case (phase)
			PH_FLAGS: begin
				held_flags = b;
				phase = PH_TYPE_HI;
			end
			PH_TYPE_HI: begin
				held_type = {b, 8'h00};
				phase = PH_TYPE_LO;
			end
			PH_TYPE_LO: begin
				held_type = {held_type[15:8], b};
				phase = PH_SIZE_3;
			end
			PH_SIZE_3: begin
				held_size = {b, 24'h000000};
				phase = PH_SIZE_2;
			end
			PH_SIZE_2: begin
				held_size = {held_size[31:24], b, 16'h0000};
				phase = PH_SIZE_1;
			end
			PH_SIZE_1: begin
				held_size = {held_size[31:16], b, 8'h00};
				phase = PH_SIZE_0;
			end
			PH_SIZE_0: begin
				held_size = {held_size[31:8], b};
				bytes_left = held_size;
				phase = (held_size != 0) ? PH_PAYLOAD : PH_CHECK;
			end
			PH_PAYLOAD: begin
				r.result_kind  = KIND_PAYLOAD;
				r.payload_byte = b;
				r.last_payload = (bytes_left <= 1);
				if (bytes_left != 0) begin
					bytes_left = bytes_left - 1;
				end
				if (r.last_payload) begin
					phase = PH_CHECK;
				end
				pending_results.insert(pending_results.size(), r);
			end
			PH_CHECK: begin
				r.result_kind = KIND_DONE;
				r.flag_bits   = held_flags;
				r.packet_type = held_type;
				r.packet_size = held_size;
				r.check_byte  = b;
				pending_results.insert(pending_results.size(), r);
				phase = PH_HUNT;
			end
			default: begin
				phase = (b == START_BYTE) ? PH_FLAGS : PH_HUNT;
			end
		endcase
	endtask

	task automatic push_byte(input logic [7:0] b);
		wire_bytes.insert(wire_bytes.size(), '{hold: 1'b0, data: b});
		stream_count++;
	endtask

	task automatic push_hold();
		wire_bytes.insert(wire_bytes.size(), '{hold: 1'b1, data: 8'h00});
	endtask

	task automatic push_packet(input logic [7:0] flags, input logic [15:0] ptype,
			input logic [31:0] size, input int n_pay, input logic [7:0] chk);
		push_byte(START_BYTE);
		push_byte(flags);
		push_byte(ptype[15:8]);
		push_byte(ptype[7:0]);
		push_byte(size[31:24]);
		push_byte(size[23:16]);
		push_byte(size[15:8]);
		push_byte(size[7:0]);
		for (int i = 0; i < n_pay; i++) begin
			push_byte(($urandom_range(0, 7) == 0) ? START_BYTE : 8'($urandom_range(0, 255)));
		end
		if (n_pay == size) begin
			push_byte(chk);
		end
	endtask

	// sender: bursts of random length, random gaps, a drain pause on hold marks
	always @(posedge clk or negedge arst_n) begin : drive_proc
		wire_item_t head;
		if (!arst_n) begin
			stream_if.valid   <= 1'b0;
			stream_if.in_byte <= 8'h00;
			burst_left = 0;
			gap_left = 0;
			settle = 0;
		end else begin
			if (stream_if.valid && stream_if.ready) begin
				deframe_byte(stream_if.in_byte);
			end
			if (!stream_if.valid || stream_if.ready) begin
				if (wire_bytes.size() > 0 && wire_bytes[0].hold) begin
					stream_if.valid <= 1'b0;
					if (pending_results.size() == 0 && !result_if.valid) begin
						if (settle >= SETTLE_CYCLES) begin
							head = wire_bytes.pop_front();
							settle = 0;
						end else begin
							settle++;
						end
					end else begin
						settle = 0;
					end
				end else if (gap_left > 0) begin
					stream_if.valid <= 1'b0;
					gap_left--;
				end else if (wire_bytes.size() > 0) begin
					head = wire_bytes.pop_front();
					stream_if.valid   <= 1'b1;
					stream_if.in_byte <= head.data;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end else begin
					stream_if.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks every result request, stalls on a changing pattern
	always @(posedge clk or negedge arst_n) begin : check_proc
		dfrm_res_t want;
		dfrm_res_t got;
		if (!arst_n) begin
			result_if.ready <= 1'b0;
			stall_mode = 0;
			stall_span = 0;
			stall_tick = 0;
		end else begin
			if (result_if.valid && result_if.ready) begin
				got.result_kind  = result_if.result_kind;
				got.payload_byte = result_if.payload_byte;
				got.last_payload = result_if.last_payload;
				got.flag_bits    = result_if.flag_bits;
				got.packet_type  = result_if.packet_type;
				got.packet_size  = result_if.packet_size;
				got.check_byte   = result_if.check_byte;
				if (pending_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("[%0t] unexpected result: kind=%0d pay=%02h last=%0d",
							$realtime, got.result_kind, got.payload_byte, got.last_payload);
					end
				end else begin
					want = pending_results.pop_front();
					if (got.result_kind !== want.result_kind
							|| got.payload_byte !== want.payload_byte
							|| got.last_payload !== want.last_payload
							|| got.flag_bits !== want.flag_bits
							|| got.packet_type !== want.packet_type
							|| got.packet_size !== want.packet_size
							|| got.check_byte !== want.check_byte) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS) begin
							$display("[%0t] mismatch exp: kind=%0d pay=%02h last=%0d flags=%02h type=%04h size=%08h chk=%02h",
								$realtime, want.result_kind, want.payload_byte,
								want.last_payload, want.flag_bits, want.packet_type,
								want.packet_size, want.check_byte);
							$display("[%0t] mismatch got: kind=%0d pay=%02h last=%0d flags=%02h type=%04h size=%08h chk=%02h",
								$realtime, got.result_kind, got.payload_byte,
								got.last_payload, got.flag_bits, got.packet_type,
								got.packet_size, got.check_byte);
						end
					end
				end
			end
			if (stall_span == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_span = $urandom_range(16, 80);
			end else begin
				stall_span--;
			end
			stall_tick++;
			case (stall_mode)
				0: result_if.ready <= 1'b1;
				1: result_if.ready <= 1'($urandom_range(0, 1));
				2: result_if.ready <= ((stall_tick % 5) != 0);
				default: result_if.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= RUN_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stim_proc
		logic [7:0] directed[22];
		logic [31:0] size;
		logic [7:0] noise;
		int n_noise;
		int next_hold;

		arst_n = 1'b0;
		stream_if.valid = 1'b0;
		stream_if.in_byte = 8'h00;
		result_if.ready = 1'b0;

		// idle bytes, empty packet with all-ones flags and type, start byte as payload
		directed = '{8'h00, 8'hFF, 8'hAE,
			8'hAF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
			8'hAF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hAF, 8'hFF};
		foreach (directed[i]) begin
			push_byte(directed[i]);
		end
		push_hold();

		next_hold = stream_count + 120;
		while (stream_count < 530) begin
			n_noise = $urandom_range(0, 2);
			for (int i = 0; i < n_noise; i++) begin
				noise = 8'($urandom_range(0, 254));
				if (noise >= START_BYTE) begin
					noise = noise + 8'd1;
				end
				push_byte(noise);
			end
			if ($urandom_range(0, 9) == 0) begin
				size = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				size = $urandom_range(20, 48);
			end else begin
				size = $urandom_range(1, 8);
			end
			push_packet(8'($urandom), 16'($urandom), size, size, 8'($urandom));
			if (stream_count >= next_hold) begin
				push_hold();
				next_hold = stream_count + 120;
			end
		end
		// all-ones size: header capture, three payload bytes, no completion
		push_packet(8'($urandom), 16'($urandom), 32'hFFFF_FFFF, 3, 8'h00);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (wire_bytes.size() != 0 || stream_if.valid) begin
			@(posedge clk);
		end
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
